// File: rtl/core/gait_sequence_controller_macros.svh
// Assertion macros shared by the gait sequence controller RTL.
`ifndef GAIT_SEQUENCE_CONTROLLER_MACROS_SVH
`define GAIT_SEQUENCE_CONTROLLER_MACROS_SVH

// Same-cycle implication, checked on clk with reset masked.
`define GSC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk with reset masked.
`define GSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/gsc_pkg.sv
// Shared types and constants of the gait sequence controller.
package gsc_pkg;

  localparam int unsigned IdxW  = 7;
  localparam int unsigned DescW = 22;

  localparam logic [2:0] SEQ_NONE    = 3'd0;
  localparam logic [2:0] SEQ_UP      = 3'd1;
  localparam logic [2:0] SEQ_DOWN    = 3'd2;
  localparam logic [2:0] SEQ_DIRECT  = 3'd3;
  localparam logic [2:0] SEQ_REVERSE = 3'd4;

  localparam logic [1:0] REG_UP      = 2'd0;
  localparam logic [1:0] REG_DOWN    = 2'd1;
  localparam logic [1:0] REG_DIRECT  = 2'd2;
  localparam logic [1:0] REG_REVERSE = 2'd3;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_MOVE   = 3'd1,
    PH_WAIT   = 3'd2,
    PH_NEXT   = 3'd3,
    PH_CHANGE = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    STG_PREPARE = 2'd0,
    STG_MAIN    = 2'd1,
    STG_FINAL   = 2'd2
  } stage_t;

  typedef struct packed {
    logic               func;
    logic               motion_done;
    logic [2:0]         sequence_request;
    logic signed [31:0] curve_in;
    logic signed [31:0] stride_in;
  } gsc_in_t;

  typedef struct packed {
    logic               start_motion;
    logic [5:0]         motion_number;
    logic [2:0]         active_sequence;
    logic               reset_trajectory;
    logic               update_trajectory;
    logic signed [31:0] curve_out;
    logic signed [31:0] stride_out;
    logic               fatal_error;
    logic               body_up;
    logic               busy_res;
  } gsc_out_t;

  // Decoded, saturated descriptor of the running sequence.
  typedef struct packed {
    logic [IdxW-1:0] main_start;
    logic [IdxW-1:0] fin_start;
    logic [IdxW-1:0] total;
    logic            looped;
  } desc_t;

  // Engine status seen by the top level.
  typedef struct packed {
    logic halted;
    logic busy;
  } eng_status_t;

endpackage

// File: rtl/core/gsc_desc_regs.sv
// Descriptor register file with saturating decode of the selected sequence.
module gsc_desc_regs #(
  parameter int unsigned MAX_MOTIONS = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [1:0]                    wr_index,
  input  logic [gsc_pkg::DescW-1:0]     wr_data,
  input  logic [2:0]                    sel_seq,
  output gsc_pkg::desc_t                desc
);
  import gsc_pkg::*;

  localparam logic [IdxW-1:0] StartLim = IdxW'(MAX_MOTIONS - 1);
  localparam logic [IdxW-1:0] TotalLim = IdxW'(MAX_MOTIONS);

  logic [DescW-1:0] desc_r [4];
  logic [DescW-1:0] raw;
  logic [IdxW-1:0]  f_main;
  logic [IdxW-1:0]  f_fin;
  logic [IdxW-1:0]  f_total;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        desc_r[i] <= '0;
      end
    end else if (wr_en) begin
      desc_r[wr_index] <= wr_data;
    end
  end

  always_comb begin
    case (sel_seq)
      SEQ_UP:      raw = desc_r[REG_UP];
      SEQ_DOWN:    raw = desc_r[REG_DOWN];
      SEQ_DIRECT:  raw = desc_r[REG_DIRECT];
      SEQ_REVERSE: raw = desc_r[REG_REVERSE];
      default:     raw = '0;
    endcase
  end

  assign f_main  = raw[6:0];
  assign f_fin   = raw[13:7];
  assign f_total = raw[20:14];

  assign desc.main_start = (f_main > StartLim) ? StartLim : f_main;
  assign desc.fin_start  = (f_fin > StartLim) ? StartLim : f_fin;
  assign desc.total      = (f_total > TotalLim) ? TotalLim : f_total;
  assign desc.looped     = raw[21];

endmodule

// File: rtl/core/gsc_engine.sv
// Sequence engine: state registers and single-pass next-state logic.
module gsc_engine (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  fire,
  input  gsc_pkg::gsc_in_t      item,
  input  gsc_pkg::desc_t        desc,
  output logic [2:0]            cur_seq,
  output gsc_pkg::gsc_out_t     res,
  output gsc_pkg::eng_status_t  status
);
  import gsc_pkg::*;

  phase_t          phase_r, phase_nxt;
  stage_t          stage_r, stage_nxt;
  logic [IdxW-1:0] idx_r, idx_nxt;
  logic [2:0]      cur_r, cur_nxt;
  logic [2:0]      pend_r, pend_nxt;
  logic            is_up_r, is_up_nxt;
  logic            halted_r, halted_nxt;
  stage_t          stg_w;
  logic [IdxW-1:0] inc_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      stage_r  <= STG_PREPARE;
      idx_r    <= '0;
      cur_r    <= SEQ_DOWN;
      pend_r   <= SEQ_DOWN;
      is_up_r  <= 1'b0;
      halted_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      stage_r  <= stage_nxt;
      idx_r    <= idx_nxt;
      cur_r    <= cur_nxt;
      pend_r   <= pend_nxt;
      is_up_r  <= is_up_nxt;
      halted_r <= halted_nxt;
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    stage_nxt  = stage_r;
    idx_nxt    = idx_r;
    cur_nxt    = cur_r;
    pend_nxt   = pend_r;
    is_up_nxt  = is_up_r;
    halted_nxt = halted_r;
    stg_w      = stage_r;
    inc_w      = idx_r + IdxW'(1);
    res        = '0;

    if (fire) begin
      if (item.func) begin
        case (item.sequence_request)
          SEQ_NONE: pend_nxt = SEQ_NONE;
          SEQ_UP: begin
            if (!is_up_r) pend_nxt = SEQ_UP;
          end
          SEQ_DOWN: pend_nxt = SEQ_DOWN;
          SEQ_DIRECT, SEQ_REVERSE: begin
            if (is_up_r) begin
              pend_nxt              = item.sequence_request;
              res.update_trajectory = 1'b1;
              res.curve_out         = item.curve_in;
              res.stride_out        = item.stride_in;
            end
          end
          default: halted_nxt = 1'b1;
        endcase
      end else if (!halted_r) begin
        case (phase_r)
          PH_IDLE: begin
            if (cur_r != pend_r) phase_nxt = PH_CHANGE;
          end
          PH_MOVE: begin
            res.start_motion  = 1'b1;
            res.motion_number = idx_r[5:0];
            phase_nxt         = PH_WAIT;
          end
          PH_WAIT: begin
            if (item.motion_done) phase_nxt = PH_NEXT;
          end
          PH_NEXT: begin
            idx_nxt   = inc_w;
            phase_nxt = PH_MOVE;
            if (stg_w == STG_PREPARE && inc_w >= desc.main_start) stg_w = STG_MAIN;
            if (stg_w == STG_MAIN && inc_w >= desc.fin_start) begin
              if (cur_r != pend_r) begin
                idx_nxt = desc.fin_start;
                stg_w   = STG_FINAL;
              end else if (desc.looped) begin
                idx_nxt = desc.main_start;
              end else begin
                pend_nxt  = SEQ_NONE;
                phase_nxt = PH_CHANGE;
              end
            end
            if (stg_w == STG_FINAL && idx_nxt >= desc.total) phase_nxt = PH_CHANGE;
            stage_nxt = stg_w;
            is_up_nxt = (cur_r != SEQ_DOWN);
          end
          default: begin
            cur_nxt              = pend_r;
            idx_nxt              = '0;
            stage_nxt            = STG_PREPARE;
            phase_nxt            = (pend_r == SEQ_NONE) ? PH_IDLE : PH_MOVE;
            res.reset_trajectory = 1'b1;
          end
        endcase
      end
    end

    res.active_sequence = cur_nxt;
    res.fatal_error     = halted_nxt;
    res.body_up         = is_up_nxt;
    res.busy_res        = (phase_nxt != PH_IDLE);
  end

  assign cur_seq       = cur_r;
  assign status.halted = halted_r;
  assign status.busy   = (phase_r != PH_IDLE);

endmodule

// File: rtl/core/gait_sequence_controller.sv
// An accepted item passes the input register, then the result register, to the result port.
// Throughput: one item per cycle unless the result stalls; the engine steps once per item.
// A stalled result holds the input register; a new transfer is taken once the result moves on.
// Reset (rst_n low, synchronous): descriptors cleared, engine idle on the down sequence,
// body down, no fatal error, both pipeline registers empty.
// Configuration writes are taken every cycle (cfg_ready is always high).
`include "gait_sequence_controller_macros.svh"

module gait_sequence_controller #(
  parameter int unsigned MAX_MOTIONS = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  gsc_pkg::gsc_in_t           in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output gsc_pkg::gsc_out_t          out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [1:0]                 cfg_index,
  input  logic [gsc_pkg::DescW-1:0]  cfg_data
);
  import gsc_pkg::*;

  // Input register: one transfer waiting for the engine.
  logic        s1_valid_r, s1_valid_nxt;
  gsc_in_t     s1_data_r;
  // Result register.
  logic        out_valid_r, out_valid_nxt;
  gsc_out_t    out_data_r;

  logic        res_ready;
  logic        fire;
  logic [2:0]  cur_seq;
  desc_t       desc;
  gsc_out_t    res;
  eng_status_t status;
  // Start, trajectory reset and trajectory update pulses of the held result.
  logic [2:0]  res_pulses;

  // Result register can take a new value when empty or being drained this cycle.
  assign res_ready = !out_valid_r || !out_stall;
  // Engine consumes the held item whenever the result side can take it.
  assign fire      = s1_valid_r && res_ready;
  // Stall the input only while a held item cannot advance.
  assign in_stall  = s1_valid_r && !res_ready;
  assign cfg_ready = 1'b1;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (!in_stall) s1_valid_nxt = in_valid;
    out_valid_nxt = out_valid_r;
    if (res_ready) out_valid_nxt = fire;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: load on transfer, hold otherwise.
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) s1_data_r <= in_data;
    if (fire) out_data_r <= res;
  end

  // Descriptors of the four sequences, decoded for the running one.
  gsc_desc_regs #(
    .MAX_MOTIONS (MAX_MOTIONS)
  ) u_desc (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .sel_seq  (cur_seq),
    .desc     (desc)
  );

  // Phase/stage engine: advances once per consumed item.
  gsc_engine u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .item    (s1_data_r),
    .desc    (desc),
    .cur_seq (cur_seq),
    .res     (res),
    .status  (status)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign res_pulses = {out_data_r.start_motion, out_data_r.reset_trajectory,
                       out_data_r.update_trajectory};

  // Fatal error never clears once set.
  `GSC_ASSERT_NEXT(a_halt_sticky, status.halted, status.halted, "fatal error cleared")
  // A held input item is never dropped while stalled.
  `GSC_ASSERT_NEXT(a_no_drop, in_stall, s1_valid_r, "stalled input item lost")
  // At most one of start, trajectory reset and trajectory update per result.
  `GSC_ASSERT_NOW(a_one_pulse, out_valid_r, $countones(res_pulses) <= 1, "conflicting pulses")
  // A consumed item always lands in the result register.
  `GSC_ASSERT_NEXT(a_fire_result, fire, out_valid_r, "engine result lost")

endmodule

// File: verif/testbench.sv
// Self-checking testbench of the gait sequence controller: directed table, random traffic, then invalid ids.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import gsc_pkg::*;

  localparam int MaxMotions = 64;
  localparam int SegmentCount = 7;
  localparam int SegmentItems = 200;
  // First id past the last valid sequence; this id and the two above it are invalid.
  localparam logic [2:0] SeqFirstInvalid = SEQ_REVERSE + 3'd1;

  typedef struct {
    gsc_in_t  item;
    bit       typed;
    gsc_out_t result;
  } stim_row_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  gsc_in_t          in_data = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  gsc_out_t         out_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [1:0]       cfg_index = REG_UP;
  logic [DescW-1:0] cfg_data = '0;

  // Chance in a hundred that the sender idles or the receiver stalls on a cycle.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int failures = 0;

  // Shadow state of the controller, kept in step with every accepted transfer.
  logic [DescW-1:0] desc_regs [4] = '{default: '0};
  phase_t           eng_phase = PH_IDLE;
  stage_t           eng_stage = STG_PREPARE;
  logic [IdxW-1:0]  step_idx = '0;
  logic [2:0]       cur_seq = SEQ_DOWN;
  logic [2:0]       next_seq = SEQ_DOWN;
  logic             body_raised = 1'b0;
  logic             stopped = 1'b0;

  gsc_out_t  awaited_results [$];
  stim_row_t script [$];

  gait_sequence_controller #(.MAX_MOTIONS(MaxMotions)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Advance the shadow controller by one tick or select and return the result it produces.
  function automatic gsc_out_t predict_gait_step(input gsc_in_t it);
    gsc_out_t         r;
    logic [DescW-1:0] d;
    logic [IdxW-1:0]  main_b;
    logic [IdxW-1:0]  fin_b;
    logic [IdxW-1:0]  total;
    logic             looped;
    r = '0;
    if (it.func) begin
      case (it.sequence_request)
        SEQ_NONE: next_seq = SEQ_NONE;
        SEQ_UP: if (!body_raised) next_seq = SEQ_UP;
        SEQ_DOWN: next_seq = SEQ_DOWN;
        SEQ_DIRECT, SEQ_REVERSE: begin
          if (body_raised) begin
            next_seq = it.sequence_request;
            r.update_trajectory = 1'b1;
            r.curve_out = it.curve_in;
            r.stride_out = it.stride_in;
          end
        end
        default: stopped = 1'b1;
      endcase
    end else if (!stopped) begin
      // Sequence none has no register and reads as all zeros.
      if (cur_seq >= SEQ_UP && cur_seq <= SEQ_REVERSE) d = desc_regs[2'(cur_seq - SEQ_UP)];
      else d = '0;
      main_b = (d[6:0] > IdxW'(MaxMotions - 1)) ? IdxW'(MaxMotions - 1) : d[6:0];
      fin_b  = (d[13:7] > IdxW'(MaxMotions - 1)) ? IdxW'(MaxMotions - 1) : d[13:7];
      total  = (d[20:14] > IdxW'(MaxMotions)) ? IdxW'(MaxMotions) : d[20:14];
      looped = d[21];
      case (eng_phase)
        PH_IDLE: if (cur_seq != next_seq) eng_phase = PH_CHANGE;
        PH_MOVE: begin
          r.start_motion = 1'b1;
          r.motion_number = step_idx[5:0];
          eng_phase = PH_WAIT;
        end
        PH_WAIT: if (it.motion_done) eng_phase = PH_NEXT;
        PH_NEXT: begin
          step_idx = step_idx + 1'b1;
          eng_phase = PH_MOVE;
          if (eng_stage == STG_PREPARE && step_idx >= main_b) eng_stage = STG_MAIN;
          if (eng_stage == STG_MAIN && step_idx >= fin_b) begin
            if (cur_seq != next_seq) begin
              step_idx = fin_b;
              eng_stage = STG_FINAL;
            end else if (looped) begin
              step_idx = main_b;
            end else begin
              next_seq = SEQ_NONE;
              eng_phase = PH_CHANGE;
            end
          end
          if (eng_stage == STG_FINAL && step_idx >= total) eng_phase = PH_CHANGE;
          body_raised = (cur_seq != SEQ_DOWN);
        end
        default: begin
          cur_seq = next_seq;
          step_idx = '0;
          eng_stage = STG_PREPARE;
          if (cur_seq == SEQ_NONE) eng_phase = PH_IDLE;
          else eng_phase = PH_MOVE;
          r.reset_trajectory = 1'b1;
        end
      endcase
    end
    r.active_sequence = cur_seq;
    r.fatal_error = stopped;
    r.body_up = body_raised;
    r.busy_res = (eng_phase != PH_IDLE);
    return r;
  endfunction

  function automatic gsc_in_t tick_item(input logic done);
    gsc_in_t it;
    it = '0;
    it.motion_done = done;
    return it;
  endfunction

  function automatic gsc_in_t select_item(input logic [2:0] req, input logic [31:0] curve,
                                          input logic [31:0] stride);
    gsc_in_t it;
    it.func = 1'b1;
    it.motion_done = 1'b0;
    it.sequence_request = req;
    it.curve_in = curve;
    it.stride_in = stride;
    return it;
  endfunction

  // Result with no trajectory update and no fatal error.
  function automatic gsc_out_t status_word(input logic start, input logic [5:0] num,
                                           input logic [2:0] act, input logic rst,
                                           input logic body, input logic busy);
    gsc_out_t r;
    r = '0;
    r.start_motion = start;
    r.motion_number = num;
    r.active_sequence = act;
    r.reset_trajectory = rst;
    r.body_up = body;
    r.busy_res = busy;
    return r;
  endfunction

  function automatic logic [DescW-1:0] pack_descriptor(input int main_start, input int fin_start,
                                                      input int total, input bit looped);
    return {looped, 7'(total), 7'(fin_start), 7'(main_start)};
  endfunction

  // Mostly short sequences so they finish often; now and then any 22-bit value.
  function automatic logic [DescW-1:0] random_descriptor();
    int m;
    int f;
    if ($urandom_range(0, 7) == 0) return DescW'($urandom());
    m = $urandom_range(0, 4);
    f = m + $urandom_range(0, 4);
    return pack_descriptor(m, f, f + $urandom_range(0, 4), $urandom_range(0, 1));
  endfunction

  task automatic add_row(input gsc_in_t item, input bit typed = 1'b0,
                         input gsc_out_t result = '0);
    stim_row_t row;
    row.item = item;
    row.typed = typed;
    row.result = result;
    script.push_back(row);
  endtask

  // Offer one item, hold it through stalls, and record what it should produce once taken.
  task automatic send_item(input gsc_in_t item, input bit typed, input gsc_out_t typed_result);
    gsc_out_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = predict_gait_step(item);
    awaited_results.push_back(typed ? typed_result : predicted);
  endtask

  task automatic play_script();
    foreach (script[i]) send_item(script[i].item, script[i].typed, script[i].result);
    script.delete();
  endtask

  // Drop valid and wait until every outstanding result has been transferred.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  // Hold cfg_valid high across back-to-back writes; the caller drops it.
  task automatic write_register(input logic [1:0] idx, input logic [DescW-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    desc_regs[idx] = value;
  endtask

  task automatic program_descriptors(input logic [DescW-1:0] up_d, input logic [DescW-1:0] down_d,
                                     input logic [DescW-1:0] dir_d, input logic [DescW-1:0] rev_d);
    drain();
    write_register(REG_UP, up_d);
    write_register(REG_DOWN, down_d);
    write_register(REG_DIRECT, dir_d);
    write_register(REG_REVERSE, rev_d);
    cfg_valid <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v, input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      failures++;
    end
  endtask

  // Receiver: stall at random and compare every result transfer with the oldest expectation.
  always @(posedge clk) begin
    gsc_out_t exp_r;
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        $error("result transfer with nothing expected");
        failures++;
      end else begin
        exp_r = awaited_results.pop_front();
        check_field("start_motion", exp_r.start_motion, out_data.start_motion);
        check_field("motion_number", exp_r.motion_number, out_data.motion_number);
        check_field("active_sequence", exp_r.active_sequence, out_data.active_sequence);
        check_field("reset_trajectory", exp_r.reset_trajectory, out_data.reset_trajectory);
        check_field("update_trajectory", exp_r.update_trajectory, out_data.update_trajectory);
        check_field("curve_out", exp_r.curve_out, out_data.curve_out);
        check_field("stride_out", exp_r.stride_out, out_data.stride_out);
        check_field("fatal_error", exp_r.fatal_error, out_data.fatal_error);
        check_field("body_up", exp_r.body_up, out_data.body_up);
        check_field("busy_res", exp_r.busy_res, out_data.busy_res);
      end
    end
  end

  initial begin
    int r;
    gsc_in_t it;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 15;
    recv_stall_pct = 56;

    // Short up and down sequences, a looped walk, and a reverse walk that saturates every field.
    program_descriptors(pack_descriptor(1, 2, 3, 0), pack_descriptor(0, 1, 2, 0),
                        pack_descriptor(1, 3, 4, 1), 22'h3F_FFFF);

    // Out of reset: idle on the down sequence, body down.
    add_row(tick_item(1'b0), 1'b1, status_word(1'b0, 6'd0, SEQ_DOWN, 1'b0, 1'b0, 1'b0));
    // Walk requests while the body is down are rejected, extremes of curvature and stride; then up is requested.
    add_row(select_item(SEQ_DIRECT, 32'h7FFF_FFFF, 32'h8000_0000), 1'b1,
            status_word(1'b0, 6'd0, SEQ_DOWN, 1'b0, 1'b0, 1'b0));
    add_row(select_item(SEQ_REVERSE, 32'h8000_0000, 32'h7FFF_FFFF), 1'b1,
            status_word(1'b0, 6'd0, SEQ_DOWN, 1'b0, 1'b0, 1'b0));
    add_row(select_item(SEQ_UP, 32'h0, 32'h0), 1'b1,
            status_word(1'b0, 6'd0, SEQ_DOWN, 1'b0, 1'b0, 1'b0));
    // Idle sees the pending switch, then changes to up and starts motion zero.
    add_row(tick_item(1'b1), 1'b1, status_word(1'b0, 6'd0, SEQ_DOWN, 1'b0, 1'b0, 1'b1));
    add_row(tick_item(1'b0), 1'b1, status_word(1'b0, 6'd0, SEQ_UP, 1'b1, 1'b0, 1'b1));
    add_row(tick_item(1'b0), 1'b1, status_word(1'b1, 6'd0, SEQ_UP, 1'b0, 1'b0, 1'b1));
    add_row(tick_item(1'b0));
    add_row(tick_item(1'b1));
    add_row(tick_item(1'b0));
    // Body is up now: up is rejected, direct is taken and forwards its values.
    add_row(select_item(SEQ_UP, 32'h5555_5555, 32'hAAAA_AAAA));
    add_row(select_item(SEQ_DIRECT, 32'hFFFF_FFFF, 32'h0));
    // Pending switch jumps to finalize, then the engine changes to the walk.
    add_row(tick_item(1'b0));
    add_row(tick_item(1'b1));
    add_row(tick_item(1'b0));
    add_row(tick_item(1'b0));
    add_row(tick_item(1'b1));
    add_row(tick_item(1'b1));
    add_row(tick_item(1'b0));
    add_row(select_item(SEQ_REVERSE, 32'h0, 32'hFFFF_FFFF));
    add_row(select_item(SEQ_NONE, 32'h1234_5678, 32'h8765_4321));
    add_row(select_item(SEQ_DOWN, 32'h0, 32'h0));
    add_row(tick_item(1'b1));
    add_row(tick_item(1'b1));
    add_row(tick_item(1'b1));
    play_script();

    // Random traffic in segments; reprogram the descriptors between segments.
    for (int seg = 0; seg < SegmentCount; seg++) begin
      if (seg < 2) begin
        send_idle_pct = 15;
        recv_stall_pct = 56;
      end else if (seg < 4) begin
        send_idle_pct = 56;
        recv_stall_pct = 15;
      end else begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      if (seg == 1) program_descriptors('1, '1, '1, '1);
      else if (seg == 2) program_descriptors('0, '0, '0, '0);
      else program_descriptors(random_descriptor(), random_descriptor(),
                               random_descriptor(), random_descriptor());
      for (int n = 0; n < SegmentItems; n++) begin
        // Mostly ticks so sequences run to the end; selects steer between them.
        if ($urandom_range(0, 99) < 20) begin
          r = $urandom_range(0, 99);
          it = select_item(r < 5 ? SEQ_NONE : r < 30 ? SEQ_UP : r < 50 ? SEQ_DOWN :
                           r < 75 ? SEQ_DIRECT : SEQ_REVERSE, $urandom(), $urandom());
        end else begin
          it = tick_item($urandom_range(0, 99) < 70);
          it.curve_in = $urandom();
          it.stride_in = $urandom();
        end
        send_item(it, 1'b0, '0);
      end
    end

    // Invalid ids latch the fatal error; ticks stop but requests are still handled.
    add_row(select_item(SeqFirstInvalid, 32'h0, 32'h0));
    add_row(tick_item(1'b1));
    add_row(tick_item(1'b0));
    add_row(select_item(SeqFirstInvalid + 3'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    add_row(select_item(SEQ_DIRECT, 32'h0F0F_0F0F, 32'hF0F0_F0F0));
    add_row(select_item(SEQ_UP, 32'h0, 32'h0));
    add_row(select_item(SeqFirstInvalid + 3'd2, 32'h8000_0000, 32'h7FFF_FFFF));
    add_row(tick_item(1'b1));
    play_script();

    drain();
    repeat (8) @(posedge clk);
    if (failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Bound the run well past the slowest legal schedule.
  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/gsc_pkg.sv
rtl/core/gsc_desc_regs.sv
rtl/core/gsc_engine.sv
rtl/core/gait_sequence_controller.sv
verif/testbench.sv
